[sv/obb_pkg.sv]
// Package with shared types and constants for the oriented box contact tracker.
package obb_pkg;

   localparam int MaxContactsDefault = 16;
   localparam int IdBitsDefault      = 16;

   // Event codes reported on the result channel.
   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_ENTER = 2'd1,
      EV_STAY  = 2'd2,
      EV_EXIT  = 2'd3
   } event_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_CX  = 3'd0,
      REG_CY  = 3'd1,
      REG_RX  = 3'd2,
      REG_RY  = 3'd3,
      REG_HW  = 3'd4,
      REG_HH  = 3'd5,
      REG_ACT = 3'd6
   } reg_type;

   // Sequencer states of the geometry unit.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DOT,
      ST_MUL,
      ST_CMP,
      ST_TABLE,
      ST_OUT
   } state_type;

   // Request from the geometry sequencer to the contact table.
   typedef struct packed {
      logic start;
      logic overlap;
   } tbl_req_type;

   // Answer from the contact table.
   typedef struct packed {
      logic      done;
      event_type kind;
      logic      full;
   } tbl_rsp_type;

endpackage

[sv/obb_table.sv]
// Contact table: scans stored IDs one slot per cycle and updates on enter or exit.
module obb_table #(
   parameter int MAX_CONTACTS = obb_pkg::MaxContactsDefault,
   parameter int ID_BITS      = obb_pkg::IdBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [ID_BITS-1:0]   id,
   input  obb_pkg::tbl_req_type req,
   output obb_pkg::tbl_rsp_type rsp
);
   import obb_pkg::*;

   localparam int SW = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
   localparam int CW = $clog2(MAX_CONTACTS + 1);

   logic [ID_BITS-1:0]    ids_ff [MAX_CONTACTS];
   logic [ID_BITS-1:0]    rd_id_ff;
   logic [MAX_CONTACTS-1:0] valid_ff, valid_in;
   logic                  busy_ff, busy_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  found_ff, found_in;
   logic [SW-1:0]         slot_ff, slot_in;
   logic                  free_ok_ff, free_ok_in;
   logic [SW-1:0]         free_ff, free_in;
   logic                  ovl_ff, ovl_in;
   logic                  wr_en;
   logic [SW-1:0]         wr_slot;
   logic [SW-1:0]         idx;
   logic [SW-1:0]         rd_addr;
   logic                  last;

   assign idx  = cnt_ff[SW-1:0];
   assign last = (cnt_ff == CW'(MAX_CONTACTS - 1));
   // The slot scanned next is read in the cycle before it is scanned.
   assign rd_addr = cnt_in[SW-1:0];

   // Scan sequencer and final update decision.
   always_comb begin
      busy_in    = busy_ff;
      cnt_in     = cnt_ff;
      found_in   = found_ff;
      slot_in    = slot_ff;
      free_ok_in = free_ok_ff;
      free_in    = free_ff;
      ovl_in     = ovl_ff;
      valid_in   = valid_ff;
      wr_en      = 1'b0;
      wr_slot    = free_ff;
      rsp        = '{done: 1'b0, kind: EV_NONE, full: 1'b0};
      if (!busy_ff) begin
         if (req.start) begin
            busy_in    = 1'b1;
            cnt_in     = '0;
            found_in   = 1'b0;
            free_ok_in = 1'b0;
            ovl_in     = req.overlap;
         end
      end else if (cnt_ff != CW'(MAX_CONTACTS)) begin
         if (valid_ff[idx]) begin
            if (!found_ff && rd_id_ff == id) begin
               found_in = 1'b1;
               slot_in  = idx;
            end
         end else if (!free_ok_ff) begin
            free_ok_in = 1'b1;
            free_in    = idx;
         end
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            cnt_in = CW'(MAX_CONTACTS);
         end
      end else begin
         busy_in  = 1'b0;
         rsp.done = 1'b1;
         if (!ovl_ff) begin
            if (found_ff) begin
               valid_in[slot_ff] = 1'b0;
               rsp.kind = EV_EXIT;
            end
         end else if (found_ff) begin
            rsp.kind = EV_STAY;
         end else begin
            rsp.kind = EV_ENTER;
            if (free_ok_ff) begin
               wr_en = 1'b1;
               valid_in[free_ff] = 1'b1;
            end else begin
               rsp.full = 1'b1;
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
      found_ff   <= found_in;
      slot_ff    <= slot_in;
      free_ok_ff <= free_ok_in;
      free_ff    <= free_in;
      ovl_ff     <= ovl_in;
   end

   // ID storage with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ids_ff[wr_slot] <= id;
      end
      rd_id_ff <= ids_ff[rd_addr];
   end

endmodule

[sv/obb_geom.sv]
// Separating axis test, one axis at a time through one shared multiplier.
module obb_geom (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [24:0] dx,
   input  logic signed [24:0] dy,
   input  logic signed [15:0] srx,
   input  logic signed [15:0] sry,
   input  logic signed [15:0] orx,
   input  logic signed [15:0] ory,
   input  logic [22:0]        shw,
   input  logic [22:0]        shh,
   input  logic [22:0]        ohw,
   input  logic [22:0]        ohh,
   output logic               done,
   output logic               overlap
);
   import obb_pkg::*;

   // One product: 26x26 signed.
   logic signed [25:0] ma, mb;
   logic signed [51:0] prod;
   assign prod = ma * mb;

   state_type          st_ff, st_in;
   logic [1:0]         ax_ff, ax_in;   // axis under test
   logic [2:0]         k_ff, k_in;     // step within axis
   logic signed [52:0] acc_ff, acc_in; // dot product accumulator
   logic [56:0]        sum_ff, sum_in; // extent sum, units 2^-28
   logic               sep_ff, sep_in;
   logic [33:0]        dotm_ff, dotm_in;

   // Axis components carry one extra bit so that negating -32768 stays exact.
   logic signed [16:0] aix, aiy, ajx, ajy;
   logic [22:0]        hj;
   logic [52:0]        accm;

   function automatic logic signed [16:0] neg_ext(input logic signed [15:0] v);
      neg_ext = -17'(v);
   endfunction

   // Axis components: axis n is right or up of a box.
   always_comb begin
      unique case (ax_ff)
         2'd0: begin aix = 17'(srx);     aiy = 17'(sry); end
         2'd1: begin aix = neg_ext(sry); aiy = 17'(srx); end
         2'd2: begin aix = 17'(orx);     aiy = 17'(ory); end
         default: begin aix = neg_ext(ory); aiy = 17'(orx); end
      endcase
      unique case (k_ff[2:1])
         2'd0: begin ajx = 17'(srx);     ajy = 17'(sry); hj = shw; end
         2'd1: begin ajx = neg_ext(sry); ajy = 17'(srx); hj = shh; end
         2'd2: begin ajx = 17'(orx);     ajy = 17'(ory); hj = ohw; end
         default: begin ajx = neg_ext(ory); ajy = 17'(orx); hj = ohh; end
      endcase
   end

   assign accm = acc_ff[52] ? 53'(-acc_ff) : 53'(acc_ff);

   // Sequencer. Per axis: for each other axis two steps (x term, y term), a magnitude
   // step and two extent half-product steps; then two center offset steps and a compare.
   always_comb begin
      st_in = st_ff; ax_in = ax_ff; k_in = k_ff; acc_in = acc_ff;
      sum_in = sum_ff; sep_in = sep_ff; dotm_in = dotm_ff;
      ma = '0; mb = '0; done = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (start) begin
               st_in = ST_DOT; ax_in = '0; k_in = '0; acc_in = '0;
               sum_in = '0; sep_in = 1'b0;
            end
         end
         ST_DOT: begin
            // k bit0 selects x or y term of axis i dot axis j
            ma = k_ff[0] ? 26'(aiy) : 26'(aix);
            mb = k_ff[0] ? 26'(ajy) : 26'(ajx);
            if (!k_ff[0]) begin
               acc_in = 53'(prod);
               k_in   = k_ff + 3'd1;
            end else begin
               acc_in = acc_ff + 53'(prod);
               st_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            dotm_in = accm[33:0];
            st_in   = ST_CMP;
            k_in    = k_ff;
            // Magnitude times extent is done in the ST_CMP and ST_TABLE states below.
         end
         ST_CMP: begin
            // |a_i.a_j| fits 32 bits; split into two 17-bit halves times h.
            ma = 26'({9'd0, dotm_ff[16:0]});
            mb = 26'({3'd0, hj});
            sum_in = sum_ff + 57'(prod[39:0]);
            st_in = ST_TABLE;
         end
         ST_TABLE: begin
            ma = 26'({9'd0, dotm_ff[33:17]});
            mb = 26'({3'd0, hj});
            sum_in = sum_ff + (57'(prod[39:0]) << 17);
            if (k_ff == 3'd7) begin
               k_in = '0; acc_in = '0; st_in = ST_OUT;
            end else begin
               k_in = k_ff + 3'd1; st_in = ST_DOT;
            end
         end
         default: begin // ST_OUT: center offset projection then compare
            ma = k_ff[0] ? 26'(aiy) : 26'(aix);
            mb = k_ff[0] ? 26'(dy)  : 26'(dx);
            if (k_ff == 3'd0) begin
               acc_in = 53'(prod);
               k_in   = 3'd1;
            end else if (k_ff == 3'd1) begin
               acc_in = acc_ff + 53'(prod);
               k_in   = 3'd2;
            end else begin
               if (sum_ff <= (57'(accm) << 14)) begin
                  sep_in = 1'b1;
               end
               if (sum_ff <= (57'(accm) << 14) || ax_ff == 2'd3) begin
                  st_in = ST_IDLE;
                  done  = 1'b1;
               end else begin
                  ax_in = ax_ff + 2'd1; k_in = '0; sum_in = '0; st_in = ST_DOT;
               end
            end
         end
      endcase
   end

   assign overlap = !(sep_ff || (st_ff == ST_OUT && k_ff == 3'd2 &&
                                 sum_ff <= (57'(accm) << 14)));

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
      ax_ff <= ax_in; k_ff <= k_in; acc_ff <= acc_in; sum_ff <= sum_in;
      sep_ff <= sep_in; dotm_ff <= dotm_in;
   end

endmodule

[sv/obb_overlap_contact_tracker_core.sv]
// Top level of the oriented box overlap tester with contact tracking.
//
//  channel | direction | transfer condition
//  req_    | in        | req_valid && !req_stall
//  rsp_    | out       | rsp_valid && !rsp_stall
//  apb     | in        | psel && penable && pwrite && pready
//
// An item is tested one axis at a time in the shared multiplier sequencer,
// up to all four axes; a separating axis ends the test early. With has_owner
// set, a contact table scan follows. An inactive collider answers in the
// cycle after it is taken. Reset is synchronous and clears control state
// and the valid bits. A stalled result holds; the input is stalled while an
// item is in work or its result waits.
module obb_overlap_contact_tracker_core #(
   parameter int MAX_CONTACTS = obb_pkg::MaxContactsDefault,
   parameter int ID_BITS      = obb_pkg::IdBitsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [23:0] req_other_center_x,
   input  logic signed [23:0] req_other_center_y,
   input  logic signed [15:0] req_other_right_x,
   input  logic signed [15:0] req_other_right_y,
   input  logic [22:0]        req_other_half_width,
   input  logic [22:0]        req_other_half_height,
   input  logic [15:0]        req_other_id,
   input  logic               req_has_owner,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_overlap,
   output logic [1:0]         rsp_event_kind,
   output logic               rsp_table_full,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import obb_pkg::*;

   localparam int IW = (ID_BITS < 16) ? ID_BITS : 16;

   logic signed [23:0] cx_ff, cy_ff;
   logic signed [15:0] rx_ff, ry_ff;
   logic [22:0]        hw_ff, hh_ff;
   logic               act_ff;

   logic signed [23:0] ocx_ff, ocy_ff;
   logic signed [15:0] orx_ff, ory_ff;
   logic [22:0]        ohw_ff, ohh_ff;
   logic [ID_BITS-1:0] id_ff;
   logic               own_ff;

   logic               busy_ff, busy_in;
   logic               wait_tbl_ff, wait_tbl_in;
   logic               ovl_ff, ovl_in;
   logic               rv_ff, rv_in;
   logic               ro_ff, ro_in, rf_ff, rf_in;
   event_type          rk_ff, rk_in;
   logic               geo_start, geo_done, geo_ovl;
   tbl_req_type        treq;
   tbl_rsp_type        trsp;
   logic               acc;
   reg_type            ridx;

   assign pready = 1'b1;
   assign ridx   = reg_type'(paddr[4:2]);
   assign acc    = req_valid && !req_stall;
   assign req_stall = busy_ff || rv_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0; cy_ff <= '0; rx_ff <= 16'sd16384; ry_ff <= '0;
         hw_ff <= '0; hh_ff <= '0; act_ff <= 1'b1;
      end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
         unique case (ridx)
            REG_CX:  cx_ff  <= pwdata[23:0];
            REG_CY:  cy_ff  <= pwdata[23:0];
            REG_RX:  rx_ff  <= pwdata[15:0];
            REG_RY:  ry_ff  <= pwdata[15:0];
            REG_HW:  hw_ff  <= pwdata[22:0];
            REG_HH:  hh_ff  <= pwdata[22:0];
            REG_ACT: act_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Register readback.
   always_comb begin
      unique case (ridx)
         REG_CX:  prdata = 32'(unsigned'(cx_ff));
         REG_CY:  prdata = 32'(unsigned'(cy_ff));
         REG_RX:  prdata = 32'(unsigned'(rx_ff));
         REG_RY:  prdata = 32'(unsigned'(ry_ff));
         REG_HW:  prdata = 32'(hw_ff);
         REG_HH:  prdata = 32'(hh_ff);
         REG_ACT: prdata = 32'(act_ff);
         default: prdata = '0;
      endcase
   end

   // Input capture.
   always_ff @(posedge clock) begin
      if (acc) begin
         ocx_ff <= req_other_center_x; ocy_ff <= req_other_center_y;
         orx_ff <= req_other_right_x;  ory_ff <= req_other_right_y;
         ohw_ff <= req_other_half_width; ohh_ff <= req_other_half_height;
         id_ff  <= ID_BITS'(req_other_id[IW-1:0]);
         own_ff <= req_has_owner;
      end
   end

   assign geo_start = acc && act_ff;

   obb_geom u_geom (
      .clock(clock), .reset(reset), .start(geo_start),
      .dx(25'(cx_ff) - 25'(req_stall ? ocx_ff : req_other_center_x)),
      .dy(25'(cy_ff) - 25'(req_stall ? ocy_ff : req_other_center_y)),
      .srx(rx_ff), .sry(ry_ff), .orx(orx_ff), .ory(ory_ff),
      .shw(hw_ff), .shh(hh_ff), .ohw(ohw_ff), .ohh(ohh_ff),
      .done(geo_done), .overlap(geo_ovl)
   );

   assign treq = '{start: geo_done && own_ff, overlap: geo_ovl};

   obb_table #(.MAX_CONTACTS(MAX_CONTACTS), .ID_BITS(ID_BITS)) u_table (
      .clock(clock), .reset(reset), .id(id_ff), .req(treq), .rsp(trsp)
   );

   // Item control and result register.
   always_comb begin
      busy_in = busy_ff; wait_tbl_in = wait_tbl_ff; ovl_in = ovl_ff;
      rv_in = rv_ff; ro_in = ro_ff; rk_in = rk_ff; rf_in = rf_ff;
      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end
      if (acc && !act_ff) begin
         rv_in = 1'b1; ro_in = 1'b0; rk_in = EV_NONE; rf_in = 1'b0;
      end else if (acc) begin
         busy_in = 1'b1;
      end
      if (geo_done) begin
         if (own_ff) begin
            wait_tbl_in = 1'b1; ovl_in = geo_ovl;
         end else begin
            busy_in = 1'b0; rv_in = 1'b1;
            ro_in = geo_ovl; rk_in = EV_NONE; rf_in = 1'b0;
         end
      end
      if (trsp.done) begin
         busy_in = 1'b0; wait_tbl_in = 1'b0; rv_in = 1'b1;
         ro_in = ovl_ff; rk_in = trsp.kind; rf_in = trsp.full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; wait_tbl_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; wait_tbl_ff <= wait_tbl_in; rv_ff <= rv_in;
      end
      ovl_ff <= ovl_in; ro_ff <= ro_in; rk_ff <= rk_in; rf_ff <= rf_in;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_overlap    = ro_ff;
   assign rsp_event_kind = rk_ff;
   assign rsp_table_full = rf_ff;

`ifndef SYNTHESIS
   // No new transfer is taken while an item is in work.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !acc) else $error("input taken while busy");
   // A refused enter is always reported as an enter.
   a_full_enter: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rf_ff) |-> (rk_ff == EV_ENTER)) else $error("full without enter");
   // Table answers only while its item waits for it.
   a_tbl_wait: assert property (@(posedge clock) disable iff (reset)
      trsp.done |-> wait_tbl_ff) else $error("unexpected table answer");
`endif

endmodule

[dv/tb_obb_overlap_contact_tracker_core.sv]
// Testbench for the oriented box overlap tester with contact tracking.
`timescale 1ns / 100ps

module tb_obb_overlap_contact_tracker_core;
   import obb_pkg::*;

   localparam int NumContacts = 16;
   localparam longint CycleLimit = 2000000;

   // Result fields of one overlap test.
   typedef struct {
      bit        overlap;
      event_type kind;
      bit        full;
   } contact_result_type;

   // Fields of one incoming box.
   typedef struct {
      logic signed [23:0] cx;
      logic signed [23:0] cy;
      logic signed [15:0] rx;
      logic signed [15:0] ry;
      logic [22:0]        hw;
      logic [22:0]        hh;
      logic [15:0]        id;
      logic               owner;
   } other_box_type;

   // Predictor of the contact tracker with its store of pending results.
   class scoreboard_type;
      longint       own_cx, own_cy, own_rx, own_ry, own_hw, own_hh;
      bit           own_active;
      bit [15:0]    ids[NumContacts];
      bit           used[NumContacts];
      contact_result_type pending[$];
      int           errors;
      int           checked;

      function void clear();
         own_cx = 0; own_cy = 0; own_rx = 16384; own_ry = 0;
         own_hw = 0; own_hh = 0; own_active = 1;
         foreach (used[i]) begin
            used[i] = 0;
            ids[i] = 0;
         end
      endfunction

      function void set_reg(reg_type idx, logic [31:0] v);
         case (idx)
            REG_CX: own_cx = longint'($signed(v[23:0]));
            REG_CY: own_cy = longint'($signed(v[23:0]));
            REG_RX: own_rx = longint'($signed(v[15:0]));
            REG_RY: own_ry = longint'($signed(v[15:0]));
            REG_HW: own_hw = longint'(v[22:0]);
            REG_HH: own_hh = longint'(v[22:0]);
            REG_ACT: own_active = v[0];
            default: ;
         endcase
      endfunction

      static function longint absval(longint v);
         return v < 0 ? -v : v;
      endfunction

      // Note one accepted box and predict its result.
      function void note_box(other_box_type b);
         contact_result_type r;
         longint ax[4], ay[4], h[4];
         longint dx, dy, sum, proj;
         bit sep;
         int slot, free_slot;
         r.overlap = 0; r.kind = EV_NONE; r.full = 0;
         if (!own_active) begin
            pending.push_back(r);
            return;
         end
         ax[0] = own_rx; ay[0] = own_ry;
         ax[1] = -own_ry; ay[1] = own_rx;
         ax[2] = longint'(b.rx); ay[2] = longint'(b.ry);
         ax[3] = -longint'(b.ry); ay[3] = longint'(b.rx);
         h[0] = own_hw; h[1] = own_hh;
         h[2] = longint'({1'b0, b.hw}); h[3] = longint'({1'b0, b.hh});
         dx = own_cx - longint'(b.cx);
         dy = own_cy - longint'(b.cy);
         sep = 0;
         // Products stay well inside 64 bits: |dot| <= 2^31, extents < 2^23.
         for (int i = 0; i < 4 && !sep; i++) begin
            sum = 0;
            for (int j = 0; j < 4; j++)
               sum += absval(ax[i] * ax[j] + ay[i] * ay[j]) * h[j];
            proj = absval(ax[i] * dx + ay[i] * dy) <<< 14;
            if (sum <= proj) sep = 1;
         end
         r.overlap = !sep;
         if (b.owner) begin
            slot = -1; free_slot = -1;
            for (int i = 0; i < NumContacts; i++) begin
               if (used[i]) begin
                  if (slot < 0 && ids[i] == b.id) slot = i;
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            if (sep) begin
               if (slot >= 0) begin
                  used[slot] = 0;
                  r.kind = EV_EXIT;
               end
            end else if (slot >= 0) begin
               r.kind = EV_STAY;
            end else begin
               r.kind = EV_ENTER;
               if (free_slot >= 0) begin
                  ids[free_slot] = b.id;
                  used[free_slot] = 1;
               end else begin
                  r.full = 1;
               end
            end
         end
         pending.push_back(r);
      endfunction

      // Compare one result transfer with the oldest prediction.
      function void check_result(bit ov, logic [1:0] kind, bit full);
         contact_result_type e;
         if (pending.size() == 0) begin
            $error("result transfer with no prediction pending");
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (ov !== e.overlap) begin
            $error("overlap: expected %0d actual %0d", e.overlap, ov);
            errors++;
         end
         if (kind !== e.kind) begin
            $error("event_kind: expected %0d actual %0d", e.kind, kind);
            errors++;
         end
         if (full !== e.full) begin
            $error("table_full: expected %0d actual %0d", e.full, full);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [23:0] req_other_center_x = 0;
   logic signed [23:0] req_other_center_y = 0;
   logic signed [15:0] req_other_right_x = 0;
   logic signed [15:0] req_other_right_y = 0;
   logic [22:0] req_other_half_width = 0;
   logic [22:0] req_other_half_height = 0;
   logic [15:0] req_other_id = 0;
   logic req_has_owner = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_overlap;
   logic [1:0] rsp_event_kind;
   logic rsp_table_full;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [4:0] paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic pready;

   scoreboard_type sb = new();
   longint cycles = 0;
   bit hold_off = 0;
   bit long_hold = 0;
   int box_count = 0;
   int owner_count = 0;

   always #5 clock = ~clock;

   obb_overlap_contact_tracker_core u_top (.*);

   // Cycle limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Result side: check each transfer and stall at random.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_overlap, rsp_event_kind, rsp_table_full);
         if (long_hold)
            rsp_stall <= 1;
         else if (hold_off)
            rsp_stall <= 0;
         else if ($urandom_range(0, 99) < 25)
            rsp_stall <= 1;
         else
            rsp_stall <= 0;
      end
   end

   // Long receiver hold-off, counted in its own process.
   task automatic hold_results(int n);
      long_hold = 1;
      repeat (n) @(posedge clock);
      long_hold = 0;
   endtask

   // One write: setup, access, then idle before the next driver step.
   task automatic write_reg(reg_type idx, logic [31:0] v);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= 5'(4 * int'(idx)); pwdata <= v;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.set_reg(idx, v);
      psel <= 0; penable <= 0; pwrite <= 0;
      @(posedge clock);
   endtask

   // Wait for all results, then let the block settle before a register write.
   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // The block stalls right after each transfer, so a gap comes before each offer.
   task automatic send_box(other_box_type b);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
            $urandom_range(1, 3);
      repeat (gap) @(posedge clock);
      req_valid <= 1;
      req_other_center_x <= b.cx; req_other_center_y <= b.cy;
      req_other_right_x <= b.rx;  req_other_right_y <= b.ry;
      req_other_half_width <= b.hw; req_other_half_height <= b.hh;
      req_other_id <= b.id; req_has_owner <= b.owner;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_box(b);
      box_count++;
      if (b.owner) owner_count++;
      req_valid <= 0;
   endtask

   function automatic logic signed [15:0] rand_axis();
      case ($urandom_range(0, 5))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'sd0;
         3: return 16'($urandom);
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   // Mostly boxes near the own box with a small pool of IDs.
   function automatic other_box_type rand_box(int spread);
      other_box_type b;
      if ($urandom_range(0, 19) == 0) begin
         b.cx = 24'($urandom); b.cy = 24'($urandom);
         b.hw = 23'($urandom); b.hh = 23'($urandom);
      end else begin
         b.cx = 24'(sb.own_cx + $signed($urandom_range(0, 2 * spread)) - spread);
         b.cy = 24'(sb.own_cy + $signed($urandom_range(0, 2 * spread)) - spread);
         b.hw = 23'($urandom_range(0, spread));
         b.hh = 23'($urandom_range(0, spread));
      end
      b.rx = rand_axis(); b.ry = rand_axis();
      b.id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 23));
      b.owner = $urandom_range(0, 4) != 0;
      return b;
   endfunction

   task automatic set_pose(int spread);
      write_reg(REG_CX, $urandom);
      write_reg(REG_CY, $urandom);
      write_reg(REG_RX, 32'(rand_axis()));
      write_reg(REG_RY, 32'(rand_axis()));
      write_reg(REG_HW, $urandom_range(0, spread));
      write_reg(REG_HH, $urandom_range(0, spread));
   endtask

   initial begin
      other_box_type b;
      sb.clear();
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, enter/stay/exit, full table, no owner, inactive.
      write_reg(REG_HW, 32'h100);
      write_reg(REG_HH, 32'h100);
      b = '{cx: 0, cy: 0, rx: 16384, ry: 0, hw: 23'h100, hh: 23'h100, id: 7, owner: 1};
      send_box(b);                      // enter
      send_box(b);                      // stay
      b.cx = 24'sh7FFFFF; send_box(b);  // exit
      b.cx = -24'sh800000; send_box(b); // separated, not in table
      b.cx = 0; b.rx = -16384; b.ry = 16384; b.hw = 23'h7FFFFF; b.hh = 23'h7FFFFF;
      for (int i = 0; i < 17; i++) begin
         b.id = 16'(100 + i); send_box(b); // fills the table, then refuses
      end
      b.owner = 0; b.id = 16'hFFFF; send_box(b);
      b.owner = 1; b.rx = 16'sh7FFF; b.ry = 16'sh8000; b.hw = 0; b.hh = 0;
      b.cy = 24'sh7FFFFF; send_box(b);
      drain();
      write_reg(REG_ACT, 0);
      b.id = 100; send_box(b);
      drain();
      write_reg(REG_ACT, 1);
      write_reg(REG_CX, 32'h7FFFFF); write_reg(REG_CY, 32'h800000);
      write_reg(REG_RX, 32'hFFFF); write_reg(REG_RY, 32'h8000);
      write_reg(REG_HW, 32'h7FFFFF); write_reg(REG_HH, 32'h7FFFFF);
      for (int i = 0; i < 3; i++) send_box(rand_box(1 << 20));
      drain();

      // Receiver holds off while the sender keeps offering.
      fork
         hold_results(600);
         for (int i = 0; i < 6; i++) send_box(rand_box(4096));
      join

      // Random phases across several poses.
      for (int p = 0; p < 8; p++) begin
         int spread;
         drain();
         spread = (p % 3 == 0) ? 4096 : ((p % 3 == 1) ? 1 << 16 : 1 << 22);
         set_pose(spread);
         write_reg(REG_ACT, (p == 5) ? 0 : 1);
         hold_off = (p == 2);
         for (int i = 0; i < 90; i++) send_box(rand_box(spread));
         hold_off = 0;
      end
      drain();

      $display("Tested %0d boxes (%0d with contact tracking), %0d results checked.",
               box_count, owner_count, sb.checked);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
